// File: sv/ppmfa_pkg.sv
`timescale 1ns / 1ps

package ppmfa_pkg;

	localparam int EDGE_DEPTH   = 96;
	localparam int MAX_CHANNELS = 16;
	localparam int Q_DEPTH      = 2;

	localparam int IDX_W  = $clog2(EDGE_DEPTH);
	localparam int POS_W  = $clog2(EDGE_DEPTH + 1);
	localparam int SUM_W  = POS_W + 1;
	localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
	localparam int CSEL_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int QPTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W = $clog2(Q_DEPTH + 1);

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [NCH_W-1:0]  nch_t;
	typedef logic [QPTR_W-1:0] qptr_t;
	typedef logic [QCNT_W-1:0] qcnt_t;

	localparam idx_t  IDX_LAST   = idx_t'(EDGE_DEPTH - 1);
	localparam pos_t  LAST_POS   = pos_t'(EDGE_DEPTH - 1);
	localparam pos_t  DEPTH_POS  = pos_t'(EDGE_DEPTH);
	localparam sum_t  DEPTH_SUM  = sum_t'(EDGE_DEPTH);
	localparam nch_t  MAX_NCH    = nch_t'(MAX_CHANNELS);
	localparam qptr_t QPTR_LAST  = qptr_t'(Q_DEPTH - 1);
	localparam qcnt_t QCNT_FULL  = qcnt_t'(Q_DEPTH);

	localparam logic [15:0] SYNC_GAP_RESET = 16'd2500;

	localparam logic OP_EDGE   = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	localparam logic [2:0] ST_NONEW    = 3'd0;
	localparam logic [2:0] ST_WAIT     = 3'd1;
	localparam logic [2:0] ST_NOSYNC   = 3'd2;
	localparam logic [2:0] ST_STRADDLE = 3'd3;
	localparam logic [2:0] ST_MEASURED = 3'd4;

	typedef enum logic [1:0] {
		CMD_EDGE,
		CMD_NONEW,
		CMD_WAIT,
		CMD_RUN
	} cmd_kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_CHECK,
		BK_WALK,
		BK_EMIT,
		BK_SINGLE
	} back_state_t;

	typedef struct packed {
		logic        operation;
		logic [31:0] timestamp_us;
		logic        rising;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        idle_high;
		logic [31:0] mark_us;
		logic [31:0] frame_len;
		logic [4:0]  channel_count;
		logic [3:0]  channel_index;
		logic [15:0] channel_value;
		logic        last;
	} result_t;

	typedef struct packed {
		cmd_kind_t   kind;
		idx_t        addr;
		logic [31:0] stamp;
		logic        level;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic full;
	} qstat_t;

endpackage

// File: sv/ppmfa_queue.sv
`timescale 1ns / 1ps

module ppmfa_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ppmfa_pkg::cmd_t   push_cmd,
	input  logic              pop,
	output ppmfa_pkg::cmd_t   pop_cmd,
	output ppmfa_pkg::qstat_t qstat
);

	ppmfa_pkg::cmd_t  slot_q [ppmfa_pkg::Q_DEPTH];
	ppmfa_pkg::qptr_t wptr_q;
	ppmfa_pkg::qptr_t rptr_q;
	ppmfa_pkg::qcnt_t cnt_q;

	assign qstat.valid = (cnt_q != '0);
	assign qstat.full  = (cnt_q == ppmfa_pkg::QCNT_FULL);
	assign pop_cmd     = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == ppmfa_pkg::QPTR_LAST) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == ppmfa_pkg::QPTR_LAST) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ppmfa_pkg::QCNT_FULL)
		else $error("queue count beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count did not advance on push");

endmodule

// File: sv/ppmfa_front.sv
`timescale 1ns / 1ps

module ppmfa_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ppmfa_pkg::item_t  item,
	input  ppmfa_pkg::qstat_t qstat,
	output logic              push,
	output ppmfa_pkg::cmd_t   cmd
);

	ppmfa_pkg::idx_t wr_idx_q;
	logic            ring_full_q;
	logic            new_q;

	assign busy = qstat.full;
	assign push = start && !qstat.full;

	// classify the word against the ring state as it stands at acceptance
	always_comb begin
		cmd.addr  = wr_idx_q;
		cmd.stamp = item.timestamp_us;
		cmd.level = item.rising;
		priority if (item.operation == ppmfa_pkg::OP_EDGE) begin
			cmd.kind = ppmfa_pkg::CMD_EDGE;
		end else if (!new_q) begin
			cmd.kind = ppmfa_pkg::CMD_NONEW;
		end else if (!ring_full_q) begin
			cmd.kind = ppmfa_pkg::CMD_WAIT;
		end else begin
			cmd.kind = ppmfa_pkg::CMD_RUN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			ring_full_q <= 1'b0;
			new_q       <= 1'b0;
		end else if (push) begin
			if (item.operation == ppmfa_pkg::OP_EDGE) begin
				new_q <= 1'b1;
				if (wr_idx_q == ppmfa_pkg::IDX_LAST) begin
					wr_idx_q    <= '0;
					ring_full_q <= 1'b1;
				end else begin
					wr_idx_q <= wr_idx_q + 1'b1;
				end
			end else begin
				new_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/ppmfa_back.sv
`timescale 1ns / 1ps

module ppmfa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sync_gap_we,
	input  logic [15:0]        sync_gap_wdata,
	input  ppmfa_pkg::qstat_t  qstat,
	input  ppmfa_pkg::cmd_t    cmd,
	output logic               pop,
	output logic               strobe,
	output ppmfa_pkg::result_t result
);

	ppmfa_pkg::back_state_t state_q, state_d;

	logic [32:0]     mem [ppmfa_pkg::EDGE_DEPTH];
	logic [15:0]     sync_gap_q;
	ppmfa_pkg::idx_t base_q;
	ppmfa_pkg::pos_t iss_q;

	logic            vld_s1;
	ppmfa_pkg::pos_t pos_s1;
	logic [31:0]     time_s1;
	logic            lvl_s1;

	logic [31:0]     prev_t_q;
	logic            prev_lvl_q;
	logic [31:0]     gap_len_q;
	ppmfa_pkg::pos_t gap_idx_q;
	logic            idle_q;

	ppmfa_pkg::pos_t first_q;
	logic [31:0]     t_first_q;
	logic [31:0]     t_even_q;
	logic [31:0]     mark_q;
	logic [31:0]     frame_q;
	ppmfa_pkg::nch_t nchan_q;
	ppmfa_pkg::nch_t ec_q;
	logic [2:0]      status_q;
	logic [15:0]     chan_q [ppmfa_pkg::MAX_CHANNELS];

	ppmfa_pkg::sum_t rd_sum, rd_wrap;
	ppmfa_pkg::idx_t rd_addr;
	ppmfa_pkg::pos_t k;
	logic [31:0]     d, slot;
	logic            mem_we, issue_en, scan_end, walk_vld, walk_finish;
	logic            k_even2, at_max, brk, even_stop;
	logic            nosync, straddle, emit_last;

	// window position to ring address
	assign rd_sum  = ppmfa_pkg::sum_t'(base_q) + ppmfa_pkg::sum_t'(iss_q);
	assign rd_wrap = (rd_sum >= ppmfa_pkg::DEPTH_SUM) ? rd_sum - ppmfa_pkg::DEPTH_SUM : rd_sum;
	assign rd_addr = rd_wrap[ppmfa_pkg::IDX_W-1:0];

	assign pop    = (state_q == ppmfa_pkg::BK_IDLE) && qstat.valid;
	assign mem_we = pop && (cmd.kind == ppmfa_pkg::CMD_EDGE);

	assign d        = time_s1 - prev_t_q;
	assign scan_end = (state_q == ppmfa_pkg::BK_SCAN) && vld_s1 && (pos_s1 == ppmfa_pkg::LAST_POS);

	assign k         = pos_s1 - first_q;
	assign k_even2   = !k[0] && (k != '0);
	assign slot      = time_s1 - t_even_q;
	assign brk       = slot > {16'b0, sync_gap_q};
	assign at_max    = (nchan_q == ppmfa_pkg::MAX_NCH);
	assign even_stop = k_even2 && (at_max || brk);
	assign walk_vld  = (state_q == ppmfa_pkg::BK_WALK) && vld_s1;
	assign walk_finish = walk_vld && (even_stop || (pos_s1 == ppmfa_pkg::LAST_POS));

	assign issue_en = ((state_q == ppmfa_pkg::BK_SCAN) || (state_q == ppmfa_pkg::BK_WALK))
		&& (iss_q < ppmfa_pkg::DEPTH_POS) && !walk_finish;

	assign nosync   = gap_len_q < {16'b0, sync_gap_q};
	assign straddle = (ppmfa_pkg::sum_t'(gap_idx_q) + ppmfa_pkg::sum_t'(3)) >= ppmfa_pkg::DEPTH_SUM;
	assign emit_last = (nchan_q == '0) || (ec_q == nchan_q - 1'b1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppmfa_pkg::BK_IDLE: begin
				if (pop) begin
					unique case (cmd.kind)
						ppmfa_pkg::CMD_EDGE:  state_d = ppmfa_pkg::BK_IDLE;
						ppmfa_pkg::CMD_NONEW: state_d = ppmfa_pkg::BK_SINGLE;
						ppmfa_pkg::CMD_WAIT:  state_d = ppmfa_pkg::BK_SINGLE;
						ppmfa_pkg::CMD_RUN:   state_d = ppmfa_pkg::BK_SCAN;
						default:              state_d = ppmfa_pkg::BK_IDLE;
					endcase
				end
			end
			ppmfa_pkg::BK_SCAN: begin
				if (scan_end) state_d = ppmfa_pkg::BK_CHECK;
			end
			ppmfa_pkg::BK_CHECK: begin
				state_d = (nosync || straddle) ? ppmfa_pkg::BK_SINGLE : ppmfa_pkg::BK_WALK;
			end
			ppmfa_pkg::BK_WALK: begin
				if (walk_finish) state_d = ppmfa_pkg::BK_EMIT;
			end
			ppmfa_pkg::BK_EMIT: begin
				if (emit_last) state_d = ppmfa_pkg::BK_IDLE;
			end
			ppmfa_pkg::BK_SINGLE: begin
				state_d = ppmfa_pkg::BK_IDLE;
			end
			default: state_d = ppmfa_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		strobe = 1'b0;
		result = '0;
		unique case (state_q)
			ppmfa_pkg::BK_SINGLE: begin
				strobe        = 1'b1;
				result.status = status_q;
				result.last   = 1'b1;
			end
			ppmfa_pkg::BK_EMIT: begin
				strobe               = 1'b1;
				result.status        = ppmfa_pkg::ST_MEASURED;
				result.idle_high     = idle_q;
				result.mark_us       = mark_q;
				result.frame_len     = frame_q;
				result.channel_count = 5'(nchan_q);
				result.channel_index = 4'(ec_q);
				result.channel_value = (nchan_q == '0) ? 16'd0
					: chan_q[ec_q[ppmfa_pkg::CSEL_W-1:0]];
				result.last          = emit_last;
			end
			default: begin
				strobe = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cmd.addr] <= {cmd.stamp, cmd.level};
		end
		{time_s1, lvl_s1} <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ppmfa_pkg::BK_IDLE;
			sync_gap_q <= ppmfa_pkg::SYNC_GAP_RESET;
			iss_q      <= '0;
			vld_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue_en;
			if (sync_gap_we) begin
				sync_gap_q <= sync_gap_wdata;
			end
			if (pop && (cmd.kind == ppmfa_pkg::CMD_RUN)) begin
				iss_q <= '0;
			end else if ((state_q == ppmfa_pkg::BK_CHECK) && !nosync && !straddle) begin
				iss_q <= gap_idx_q + 1'b1;
			end else if (issue_en) begin
				iss_q <= iss_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= iss_q;
		if (pop) begin
			status_q <= (cmd.kind == ppmfa_pkg::CMD_NONEW) ? ppmfa_pkg::ST_NONEW
				: ppmfa_pkg::ST_WAIT;
			base_q    <= cmd.addr;
			gap_len_q <= '0;
			gap_idx_q <= '0;
		end
		// first pass: find the first longest interval
		if ((state_q == ppmfa_pkg::BK_SCAN) && vld_s1) begin
			prev_t_q   <= time_s1;
			prev_lvl_q <= lvl_s1;
			if (pos_s1 == '0) begin
				idle_q <= lvl_s1;
			end else if (d > gap_len_q) begin
				gap_len_q <= d;
				gap_idx_q <= pos_s1 - 1'b1;
				idle_q    <= prev_lvl_q;
			end
		end
		if (state_q == ppmfa_pkg::BK_CHECK) begin
			status_q <= nosync ? ppmfa_pkg::ST_NOSYNC : ppmfa_pkg::ST_STRADDLE;
			first_q  <= gap_idx_q + 1'b1;
			nchan_q  <= '0;
			ec_q     <= '0;
		end
		// second pass: mark, channel slots and frame end
		if (walk_vld) begin
			if (k == '0) begin
				t_first_q <= time_s1;
				t_even_q  <= time_s1;
			end
			if (k == ppmfa_pkg::pos_t'(1)) begin
				mark_q <= time_s1 - t_first_q;
			end
			if (k_even2) begin
				if (at_max || brk) begin
					frame_q <= time_s1 - t_first_q;
				end else begin
					chan_q[nchan_q[ppmfa_pkg::CSEL_W-1:0]] <= slot[15:0];
					nchan_q  <= nchan_q + 1'b1;
					t_even_q <= time_s1;
				end
			end
			if ((pos_s1 == ppmfa_pkg::LAST_POS) && !even_stop) begin
				frame_q <= '0;
			end
		end
		if (state_q == ppmfa_pkg::BK_EMIT) begin
			ec_q <= ec_q + 1'b1;
		end
	end

	a_nchan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ppmfa_pkg::BK_WALK) || (state_q == ppmfa_pkg::BK_EMIT))
		|-> (nchan_q <= ppmfa_pkg::MAX_NCH))
		else $error("channel count beyond limit");

	a_report_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> (state_q == ppmfa_pkg::BK_IDLE))
		else $error("report did not return to idle after last word");

endmodule

// File: sv/ppm_frame_analyzer.sv
`timescale 1ns / 1ps

// PPM frame analyzer.
// Input: an item word is taken on a rising edge with start high and busy low.
// operation 0 records an edge (timestamp_us, rising) into a 96-entry ring;
// operation 1 asks for a report on the last full ring.
// A two-entry command queue sits between the intake and the report engine,
// so busy rises only when that queue is full.
// Edge words retire at one per cycle while the report engine is idle. A report
// that has new edges and a full ring reads the ring twice through one memory
// read port: a scan to find the sync gap, a check, a walk from the first mark
// to the frame end, then one result word per channel (one if there are none).
// No sync gap, a straddling frame or any other report gives a single word.
// Results: each word is on result for exactly one cycle with strobe high;
// last marks the final word of a report. The receiver cannot stall them.
// Config: sync_gap_we writes sync_gap_wdata at once; write it only when idle.
// Reset clears the queue, ring position and flags; sync gap returns to 2500.
module ppm_frame_analyzer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ppmfa_pkg::item_t   item,
	input  logic               sync_gap_we,
	input  logic [15:0]        sync_gap_wdata,
	output logic               strobe,
	output ppmfa_pkg::result_t result
);

	ppmfa_pkg::qstat_t qstat;
	ppmfa_pkg::cmd_t   push_cmd;
	ppmfa_pkg::cmd_t   pop_cmd;
	logic              push;
	logic              pop;

	ppmfa_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.qstat  (qstat),
		.push   (push),
		.cmd    (push_cmd)
	);

	ppmfa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.qstat    (qstat)
	);

	ppmfa_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.sync_gap_we    (sync_gap_we),
		.sync_gap_wdata (sync_gap_wdata),
		.qstat          (qstat),
		.cmd            (pop_cmd),
		.pop            (pop),
		.strobe         (strobe),
		.result         (result)
	);

endmodule
